// ----- hw/rtl/aes_pkg.sv -----
package aes_pkg;

    localparam int ROUNDS = 10;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DATA_W = 64;

    localparam logic [CFG_IDX_W-1:0] KEY_HIGH_IDX = 1'b0;
    localparam logic [CFG_IDX_W-1:0] KEY_LOW_IDX  = 1'b1;

    localparam logic ACT_ENCRYPT = 1'b0;
    localparam logic ACT_DECRYPT = 1'b1;

    typedef struct packed {
        logic         action;
        logic [127:0] state;
        logic [127:0] key;
    } item_t;

    localparam logic [7:0] SBOX [256] = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    function automatic logic [7:0] rcon(input logic [3:0] idx);
        logic [7:0] r;
        case (idx)
            4'd0: r = 8'h01;
            4'd1: r = 8'h02;
            4'd2: r = 8'h04;
            4'd3: r = 8'h08;
            4'd4: r = 8'h10;
            4'd5: r = 8'h20;
            4'd6: r = 8'h40;
            4'd7: r = 8'h80;
            4'd8: r = 8'h1b;
            4'd9: r = 8'h36;
            default: r = 8'h00;
        endcase
        return r;
    endfunction

    function automatic logic [7:0] sbox(input logic [7:0] x);
        return SBOX[x];
    endfunction

    // constant inverse table, built from the forward one
    function automatic logic [7:0] inv_sbox(input logic [7:0] x);
        logic [7:0] r;
        r = 8'h00;
        for (int i = 0; i < 256; i++)
        begin
            if (SBOX[i] == x)
                r = 8'(i);
        end
        return r;
    endfunction

    function automatic logic [7:0] xtime(input logic [7:0] v);
        return {v[6:0], 1'b0} ^ (v[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [7:0] gmul(input logic [7:0] a, input logic [3:0] b);
        logic [7:0] acc;
        logic [7:0] t;
        acc = 8'h00;
        t = a;
        for (int i = 0; i < 4; i++)
        begin
            if (b[i])
                acc = acc ^ t;
            t = xtime(t);
        end
        return acc;
    endfunction

    // byte i sits at bits 127-8i downto 120-8i
    function automatic logic [127:0] byte_subst(input logic [127:0] s, input logic inv);
        logic [127:0] r;
        for (int i = 0; i < 16; i++)
            r[127-8*i -: 8] = inv ? inv_sbox(s[127-8*i -: 8]) : sbox(s[127-8*i -: 8]);
        return r;
    endfunction

    function automatic logic [127:0] row_rotate(input logic [127:0] s, input logic inv);
        logic [127:0] r;
        int src;
        for (int c = 0; c < 4; c++)
        begin
            for (int w = 0; w < 4; w++)
            begin
                src = inv ? ((c + 4 - w) % 4) : ((c + w) % 4);
                r[127-8*(c*4+w) -: 8] = s[127-8*(src*4+w) -: 8];
            end
        end
        return r;
    endfunction

    function automatic logic [127:0] mix_cols(input logic [127:0] s, input logic inv);
        logic [127:0] r;
        logic [3:0]   m [4];
        logic [7:0]   v;
        if (inv)
        begin
            m[0] = 4'd14; m[1] = 4'd11; m[2] = 4'd13; m[3] = 4'd9;
        end
        else
        begin
            m[0] = 4'd2; m[1] = 4'd3; m[2] = 4'd1; m[3] = 4'd1;
        end
        for (int c = 0; c < 4; c++)
        begin
            for (int w = 0; w < 4; w++)
            begin
                v = 8'h00;
                for (int k = 0; k < 4; k++)
                    v = v ^ gmul(s[127-8*(c*4+k) -: 8], m[(k + 4 - w) % 4]);
                r[127-8*(c*4+w) -: 8] = v;
            end
        end
        return r;
    endfunction

    function automatic logic [31:0] key_core(input logic [127:0] k, input logic [7:0] rc);
        logic [31:0] w;
        for (int j = 0; j < 4; j++)
            w[31-8*j -: 8] = sbox(k[127-8*(12+((j+1)%4)) -: 8]);
        w[31:24] = w[31:24] ^ rc;
        return w;
    endfunction

    function automatic logic [127:0] key_fwd(input logic [127:0] k, input logic [7:0] rc);
        logic [127:0] n;
        n[127:96] = k[127:96] ^ key_core(k, rc);
        n[95:64]  = k[95:64] ^ n[127:96];
        n[63:32]  = k[63:32] ^ n[95:64];
        n[31:0]   = k[31:0] ^ n[63:32];
        return n;
    endfunction

    // previous round key from the current one
    function automatic logic [127:0] key_inv(input logic [127:0] n, input logic [7:0] rc);
        logic [127:0] k;
        k[31:0]   = n[31:0] ^ n[63:32];
        k[63:32]  = n[63:32] ^ n[95:64];
        k[95:64]  = n[95:64] ^ n[127:96];
        k[127:96] = n[127:96] ^ key_core(k, rc);
        return k;
    endfunction

endpackage

// ----- hw/rtl/aes_if.sv -----
interface aes_in_if;
    logic        valid;
    logic        ready;
    logic        action;
    logic [63:0] block_high;
    logic [63:0] block_low;

    modport source (output valid, output action, output block_high, output block_low,
                    input ready);
    modport sink (input valid, input action, input block_high, input block_low,
                  output ready);
endinterface

interface aes_out_if;
    logic        valid;
    logic        ready;
    logic [63:0] result_high;
    logic [63:0] result_low;

    modport source (output valid, output result_high, output result_low, input ready);
    modport sink (input valid, input result_high, input result_low, output ready);
endinterface

// ----- hw/rtl/aes128_block_cipher.sv -----
// Path: input transfer, queue write, then ten round stages, each with its own key step.
// Throughput: one block per cycle while out_ch is ready and no key rebuild is running.
// Key writes: the last round key is rebuilt, and input is not taken meanwhile.
// Reset: key registers clear to zero, pipeline and queue empty, a key rebuild follows.
module aes128_block_cipher
(
    input  logic                                clk,
    input  logic                                rst_n,
    aes_in_if.sink                              in_ch,
    aes_out_if.source                           out_ch,
    input  logic                                cfg_we,
    input  logic [aes_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [aes_pkg::CFG_DATA_W-1:0]      cfg_data
);

    logic           push;
    aes_pkg::item_t push_item;
    logic           q_not_full;
    logic           q_not_empty;
    logic           pop;
    aes_pkg::item_t head;

    aes_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_ch      (in_ch),
        .q_not_full (q_not_full),
        .push       (push),
        .push_item  (push_item)
    );

    aes_queue u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .not_full  (q_not_full),
        .pop       (pop),
        .not_empty (q_not_empty),
        .head      (head)
    );

    aes_back u_back
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_not_empty (q_not_empty),
        .head        (head),
        .pop         (pop),
        .out_ch      (out_ch)
    );

endmodule

// ----- hw/rtl/aes_queue.sv -----
module aes_queue
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  aes_pkg::item_t      push_item,
    output logic                not_full,
    input  logic                pop,
    output logic                not_empty,
    output aes_pkg::item_t      head
);

    aes_pkg::item_t data_reg [2];
    logic           wr_ptr_reg;
    logic           rd_ptr_reg;
    logic [1:0]     count_reg;
    logic [1:0]     count_next;

    assign not_full  = (count_reg != 2'd2);
    assign not_empty = (count_reg != 2'd0);
    assign head      = data_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + 2'd1;
        else if (pop && !push)
            count_next = count_reg - 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
                wr_ptr_reg <= ~wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= ~rd_ptr_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            data_reg[wr_ptr_reg] <= push_item;
    end

endmodule

// ----- hw/rtl/aes_front.sv -----
module aes_front
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [aes_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [aes_pkg::CFG_DATA_W-1:0]      cfg_data,
    aes_in_if.sink                              in_ch,
    input  logic                                q_not_full,
    output logic                                push,
    output aes_pkg::item_t                      push_item
);

    logic [63:0]  key_high_reg;
    logic [63:0]  key_low_reg;
    logic [127:0] last_key_reg;
    logic         start_reg;
    logic [3:0]   exp_cnt_reg;
    logic [127:0] key_word;
    logic [127:0] first_key;

    assign key_word = {key_high_reg, key_low_reg};

    // last round key is rebuilt after every key write and after reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_high_reg <= '0;
            key_low_reg  <= '0;
            start_reg    <= 1'b1;
            exp_cnt_reg  <= 4'd0;
        end
        else if (cfg_we)
        begin
            if (cfg_index == aes_pkg::KEY_HIGH_IDX)
                key_high_reg <= cfg_data;
            else
                key_low_reg <= cfg_data;
            start_reg <= 1'b1;
        end
        else if (start_reg)
        begin
            start_reg   <= 1'b0;
            exp_cnt_reg <= 4'(aes_pkg::ROUNDS);
        end
        else if (exp_cnt_reg != 4'd0)
        begin
            exp_cnt_reg <= exp_cnt_reg - 4'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start_reg)
            last_key_reg <= key_word;
        else if (exp_cnt_reg != 4'd0)
            last_key_reg <= aes_pkg::key_fwd(last_key_reg,
                aes_pkg::rcon(4'(aes_pkg::ROUNDS) - exp_cnt_reg));
    end

    assign in_ch.ready = q_not_full && !start_reg && (exp_cnt_reg == 4'd0);
    assign push        = in_ch.valid && in_ch.ready;

    assign first_key = (in_ch.action == aes_pkg::ACT_DECRYPT) ? last_key_reg : key_word;

    assign push_item.action = in_ch.action;
    assign push_item.key    = first_key;
    assign push_item.state  = {in_ch.block_high, in_ch.block_low} ^ first_key;

endmodule

// ----- hw/rtl/aes_back.sv -----
module aes_back
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                q_not_empty,
    input  aes_pkg::item_t      head,
    output logic                pop,
    aes_out_if.source           out_ch
);

    localparam int N = aes_pkg::ROUNDS;

    aes_pkg::item_t st_reg [1:N];
    logic           vld_reg [1:N];
    aes_pkg::item_t stg_item [0:N];
    logic           stg_vld [0:N];
    logic           rdy [1:N+1];

    // stage 0 is the queue head; registers 1..N are the rounds
    assign stg_item[0] = head;
    assign stg_vld[0]  = q_not_empty;
    assign rdy[N+1]    = out_ch.ready;
    assign pop         = q_not_empty && rdy[1];

    for (genvar i = 1; i <= N; i++)
    begin : g_round
        logic           dec;
        logic [127:0]   rk;
        logic [127:0]   t;
        logic [127:0]   mixed;
        aes_pkg::item_t nxt;

        assign stg_item[i] = st_reg[i];
        assign stg_vld[i]  = vld_reg[i];
        assign dec         = (stg_item[i-1].action == aes_pkg::ACT_DECRYPT);
        assign rdy[i]      = !vld_reg[i] || rdy[i+1];

        always_comb
        begin
            if (dec)
            begin
                rk = aes_pkg::key_inv(stg_item[i-1].key, aes_pkg::rcon(4'(N - i)));
                t  = aes_pkg::byte_subst(aes_pkg::row_rotate(stg_item[i-1].state, 1'b1), 1'b1)
                     ^ rk;
            end
            else
            begin
                rk = aes_pkg::key_fwd(stg_item[i-1].key, aes_pkg::rcon(4'(i - 1)));
                t  = aes_pkg::row_rotate(aes_pkg::byte_subst(stg_item[i-1].state, 1'b0), 1'b0);
            end
            mixed = (i < N) ? aes_pkg::mix_cols(t, dec) : t;
            nxt.action = stg_item[i-1].action;
            nxt.key    = rk;
            nxt.state  = dec ? mixed : (mixed ^ rk);
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_reg[i] <= 1'b0;
            else if (rdy[i])
                vld_reg[i] <= stg_vld[i-1];
        end

        always_ff @(posedge clk)
        begin
            if (rdy[i] && stg_vld[i-1])
                st_reg[i] <= nxt;
        end
    end

    assign out_ch.valid       = vld_reg[N];
    assign out_ch.result_high = st_reg[N].state[127:64];
    assign out_ch.result_low  = st_reg[N].state[63:0];

endmodule
